// ----- sv/rbgb_pkg.sv -----
// Package for the raster background grow block: field widths, codes,
// frame phase type and the result record. No dependencies.
package rbgb_pkg;

    // Default line-memory depth (largest supported row length).
    localparam int RBGB_MAX_WIDTH = 2048;

    // Field and register widths.
    localparam int GRAY_W  = 8;
    localparam int WIDTH_W = 12;
    localparam int TOL_W   = 8;
    localparam int CFG_DW  = 12;

    // Register reset values.
    localparam logic [WIDTH_W-1:0] WIDTH_RST = 12'd640;
    localparam logic [TOL_W-1:0]   TOL_RST   = 8'd20;

    // Configuration register indexes.
    localparam logic CFG_IMAGE_WIDTH = 1'b0;
    localparam logic CFG_TOLERANCE   = 1'b1;

    // Input opcodes.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Saturating row counter: only zero, one and more matter.
    localparam logic [1:0] ROW_ZERO = 2'd0;
    localparam logic [1:0] ROW_ONE  = 2'd1;
    localparam logic [1:0] ROW_MORE = 2'd2;

    // Frame phase.
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_RUN,
        PH_DRAIN
    } t_phase;

    // One result record.
    typedef struct packed {
        logic boundary;
        logic background;
        logic last_in_frame;
    } t_result;

    // Result push from the grow unit to the output stage.
    typedef struct packed {
        logic    push;
        t_result res;
    } t_push;

endpackage

// ----- sv/rbgb_in_if.sv -----
// Pixel request channel: valid/ready handshake with opcode and gray level.
// Depends on rbgb_pkg for the field widths.
interface rbgb_in_if
    import rbgb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [GRAY_W-1:0] gray;

    modport source (output valid, output opcode, output gray, input ready);
    modport sink   (input valid, input opcode, input gray, output ready);
endinterface

// ----- sv/rbgb_out_if.sv -----
// Result request channel: valid/ready handshake with the three result flags.
// Depends on rbgb_pkg only by convention; fields are single bits.
interface rbgb_out_if
    import rbgb_pkg::*;
();
    logic valid;
    logic ready;
    logic boundary;
    logic background;
    logic last_in_frame;

    modport source (output valid, output boundary, output background,
                    output last_in_frame, input ready);
    modport sink   (input valid, input boundary, input background,
                    input last_in_frame, output ready);
endinterface

// ----- sv/rbgb_line_mem.sv -----
// Line history memory: one write port, one read port, registered read data.
// Holds two background bits per column. Standalone, no package use.
module rbgb_line_mem #(
    parameter int DEPTH = 2048,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [1:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [1:0]    o_rdata
);

    logic [1:0] r_mem [DEPTH];
    logic [1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/rbgb_grow.sv -----
// Region grow and boundary logic: frame phase, column and row counters,
// history window with forwarding, and memory access. Uses rbgb_pkg.
module rbgb_grow
    import rbgb_pkg::*;
#(
    parameter int MAX_WIDTH = RBGB_MAX_WIDTH,
    parameter int CW        = $clog2(MAX_WIDTH)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_acc,
    input  logic               i_opcode,
    input  logic [GRAY_W-1:0]  i_gray,
    input  logic [WIDTH_W-1:0] i_width,
    input  logic [TOL_W-1:0]   i_tol,
    output logic               o_mem_we,
    output logic [CW-1:0]      o_mem_waddr,
    output logic [1:0]         o_mem_wdata,
    output logic               o_mem_re,
    output logic [CW-1:0]      o_mem_raddr,
    input  logic [1:0]         i_mem_rdata,
    output t_push              o_push
);

    localparam int EW = (CW + 1 > WIDTH_W) ? CW + 1 : WIDTH_W;
    localparam logic [EW-1:0] MAX_W = EW'(MAX_WIDTH);

    t_phase            r_phase, n_phase;
    logic [GRAY_W-1:0] r_seed, n_seed;
    logic [CW-1:0]     r_col, n_col;
    logic [1:0]        r_row, n_row;
    logic [1:0]        r_nb, n_nb;
    logic [1:0]        r_cur, n_cur;
    logic [1:0]        r_h0, n_h0;
    logic              r_fwd, n_fwd;
    logic [1:0]        r_fwd_d, n_fwd_d;

    logic [EW-1:0]     w_eff;
    logic [EW-1:0]     col_p1;
    logic              col_last;
    logic [CW-1:0]     col_next;
    logic [1:0]        nxt;
    logic [GRAY_W-1:0] absd;
    logic              in_tol;
    logic              row0, rowge2, col_nz;
    logic              self_bg, left_bg, ul_bg, bg, nl, nr, nu;
    logic              step, wr;
    logic [1:0]        wval;
    logic [CW-1:0]     raddr;

    // Effective width: zero acts as one, large values clamp to the memory depth.
    always_comb begin
        w_eff = EW'(i_width);
        if (w_eff == '0) begin
            w_eff = EW'(1);
        end else if (w_eff > MAX_W) begin
            w_eff = MAX_W;
        end
    end

    // Column stepping and neighbor terms.
    assign col_p1   = EW'(r_col) + EW'(1);
    assign col_last = (col_p1 >= w_eff);
    assign col_next = col_last ? '0 : col_p1[CW-1:0];
    assign nxt      = r_fwd ? r_fwd_d : i_mem_rdata;
    assign row0     = (r_row == ROW_ZERO);
    assign rowge2   = (r_row == ROW_MORE);
    assign col_nz   = (r_col != '0);
    assign absd     = (i_gray >= r_seed) ? (i_gray - r_seed) : (r_seed - i_gray);
    assign in_tol   = (absd <= i_tol);
    assign nl       = col_nz & r_nb[1];
    assign nr       = ~col_last & nxt[0];
    assign nu       = rowge2 & r_cur[1];
    assign raddr    = col_next + CW'(1);

    // Next state, memory access and result.
    always_comb begin
        n_phase = r_phase;
        n_seed  = r_seed;
        n_col   = r_col;
        n_row   = r_row;
        n_nb    = r_nb;
        n_cur   = r_cur;
        n_h0    = r_h0;
        n_fwd   = r_fwd;
        n_fwd_d = r_fwd_d;
        step    = 1'b0;
        wr      = 1'b0;
        wval    = 2'b00;
        o_push  = '0;
        self_bg = 1'b0;
        left_bg = 1'b0;
        ul_bg   = 1'b0;
        bg      = 1'b0;

        if (i_acc) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_opcode == OP_PIXEL) begin
                        // Seed pixel: background by definition.
                        step    = 1'b1;
                        wr      = 1'b1;
                        wval    = 2'b01;
                        n_seed  = i_gray;
                        n_nb    = 2'b01;
                        n_col   = col_next;
                        n_row   = col_last ? ROW_ONE : ROW_ZERO;
                        n_phase = PH_RUN;
                    end
                end
                PH_RUN: begin
                    if (i_opcode == OP_PIXEL) begin
                        // Grow step for this pixel, result for the pixel above.
                        step    = 1'b1;
                        wr      = 1'b1;
                        self_bg = ~row0 & r_cur[0];
                        left_bg = col_nz & r_nb[0];
                        ul_bg   = col_nz & ~row0 & r_nb[1];
                        bg      = in_tol & (left_bg | self_bg | ul_bg);
                        wval    = {self_bg, bg};
                        n_nb    = {self_bg, bg};
                        n_col   = col_next;
                        if (col_last) begin
                            n_row = row0 ? ROW_ONE : ROW_MORE;
                        end
                        o_push.push                 = ~row0;
                        o_push.res.boundary         = ~self_bg & (nl | nr | nu | bg);
                        o_push.res.background       = self_bg;
                        o_push.res.last_in_frame    = 1'b0;
                    end else if (!col_nz) begin
                        step    = 1'b1;
                        n_phase = PH_DRAIN;
                    end
                end
                PH_DRAIN: begin
                    if (i_opcode == OP_DRAIN) begin
                        step = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase

            // Drain step: emit the last row with no lower neighbor.
            if (step && i_opcode == OP_DRAIN) begin
                o_push.push              = 1'b1;
                o_push.res.boundary      = ~r_cur[0] & (nl | nr | nu);
                o_push.res.background    = r_cur[0];
                o_push.res.last_in_frame = col_last;
                if (col_last) begin
                    n_col   = '0;
                    n_row   = ROW_ZERO;
                    n_nb    = 2'b00;
                    n_phase = PH_IDLE;
                end else begin
                    n_col = col_p1[CW-1:0];
                    n_nb  = {r_cur[0], 1'b0};
                end
            end

            // Slide the history window; column zero is kept in a register.
            if (step) begin
                n_h0    = (wr && !col_nz) ? wval : r_h0;
                n_cur   = (n_col == '0) ? n_h0 : nxt;
                n_fwd   = wr && (raddr == r_col);
                n_fwd_d = wval;
            end
        end
    end

    assign o_mem_we    = wr;
    assign o_mem_waddr = r_col;
    assign o_mem_wdata = wval;
    assign o_mem_re    = step;
    assign o_mem_raddr = raddr;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_seed  <= '0;
            r_col   <= '0;
            r_row   <= ROW_ZERO;
            r_nb    <= 2'b00;
            r_fwd   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_seed  <= n_seed;
            r_col   <= n_col;
            r_row   <= n_row;
            r_nb    <= n_nb;
            r_fwd   <= n_fwd;
        end
    end

    // History window data.
    always_ff @(posedge i_clk) begin
        r_cur   <= n_cur;
        r_h0    <= n_h0;
        r_fwd_d <= n_fwd_d;
    end

endmodule

// ----- sv/rbgb_out_buf.sv -----
// Output stage: result register plus a skid register, so the input side
// keeps flowing while a result waits. Uses rbgb_pkg and rbgb_out_if.
module rbgb_out_buf
    import rbgb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_push       i_push,
    output logic        o_ready,
    rbgb_out_if.source  o_res
);

    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    r_out_v, n_out_v;
    logic    r_skid_v, n_skid_v;
    logic    pop;

    assign pop     = r_out_v & o_res.ready;
    assign o_ready = ~r_skid_v;

    // Refill the output register from the skid entry first, then from a push.
    always_comb begin
        n_out    = r_out;
        n_out_v  = r_out_v;
        n_skid   = r_skid;
        n_skid_v = r_skid_v;
        if (!r_out_v || pop) begin
            if (r_skid_v) begin
                n_out    = r_skid;
                n_out_v  = 1'b1;
                n_skid_v = 1'b0;
            end else begin
                n_out   = i_push.res;
                n_out_v = i_push.push;
            end
        end else if (i_push.push) begin
            n_skid   = i_push.res;
            n_skid_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_res.valid         = r_out_v;
    assign o_res.boundary      = r_out.boundary;
    assign o_res.background    = r_out.background;
    assign o_res.last_in_frame = r_out.last_in_frame;

endmodule

// ----- sv/raster_background_grow_boundary.sv -----
// Raster background grow with boundary mask. One request per cycle unless the
// skid register is full; the result for row r-1, column c is registered when the
// pixel of row r, column c (or the matching drain request) is accepted.
// The line memory read (registered read data) is prefetched one column ahead.
// Reset clears the phase, counters and valid flags; the line memory is not
// cleared; entries read before being written go unused, so no clear is needed.
module raster_background_grow_boundary
    import rbgb_pkg::*;
#(
    parameter int MAX_WIDTH = RBGB_MAX_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rbgb_in_if.sink           i_px,
    rbgb_out_if.source        o_res,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic [WIDTH_W-1:0] r_width;
    logic [TOL_W-1:0]   r_tol;
    logic               acc;
    logic               buf_ready;
    logic               mem_we;
    logic [CW-1:0]      mem_waddr;
    logic [1:0]         mem_wdata;
    logic               mem_re;
    logic [CW-1:0]      mem_raddr;
    logic [1:0]         mem_rdata;
    t_push              push;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WIDTH_RST;
            r_tol   <= TOL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IMAGE_WIDTH: r_width <= i_cfg_data[WIDTH_W-1:0];
                CFG_TOLERANCE:   r_tol   <= i_cfg_data[TOL_W-1:0];
                default:         r_tol   <= r_tol;
            endcase
        end
    end

    // Input handshake.
    assign i_px.ready = buf_ready;
    assign acc        = i_px.valid & buf_ready;

    rbgb_grow #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW)
    ) u_grow (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (acc),
        .i_opcode    (i_px.opcode),
        .i_gray      (i_px.gray),
        .i_width     (r_width),
        .i_tol       (r_tol),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata),
        .o_push      (push)
    );

    rbgb_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    rbgb_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_ready (buf_ready),
        .o_res   (o_res)
    );

endmodule
